// File: hw/rtl/cccs_pkg.sv
// shared types and constants for the color code control stripper
package cccs_pkg;

    localparam logic [7:0] COLOR_OPEN_BYTE = 8'h03;
    localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
    localparam logic [7:0] DELETE_BYTE     = 8'h7F;
    localparam logic [7:0] COMMA_BYTE      = 8'h2C;
    localparam logic [7:0] DIGIT_ZERO      = 8'h30;
    localparam logic [7:0] DIGIT_NINE      = 8'h39;
    localparam logic [7:0] EMPTY_BYTE      = 8'h00;

    localparam logic [1:0] MAX_DIGITS      = 2'd2;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] kept_byte;
        logic       byte_present;
        logic       final_result;
    } t_result;

    // results produced by one accepted byte, in order
    typedef struct packed {
        logic [1:0] count;
        t_result    slot0;
        t_result    slot1;
    } t_push;

endpackage

// File: hw/rtl/color_code_control_stripper.sv
// top level of the color code control stripper
// each result is written into the result queue register before it is offered at o_valid
// throughput: one input byte per cycle while o_ready is high; a byte that yields two results
//   (given-back comma plus the byte) takes two queue entries and two output transfers
// input ready holds while the four-entry result queue has room for two results
// reset (i_rst_n low, synchronous) closes any color code and empties the queue
module color_code_control_stripper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_kept_byte,
    output logic       o_byte_present,
    output logic       o_final_result
);
    import cccs_pkg::*;

    logic    accept;
    logic    room_for_two;
    t_push   push;
    t_result head;

    // a transfer is taken only when any outcome fits in the queue
    assign o_ready = room_for_two;
    assign accept  = i_valid && room_for_two;

    // color code tracking and result formation for the accepted byte
    cccs_filter u_filter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_push        (push)
    );

    // result register stage, decouples the output stall from the input
    cccs_result_fifo u_results (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_pop          (i_ready),
        .o_room_for_two (room_for_two),
        .o_not_empty    (o_valid),
        .o_head         (head)
    );

    assign o_kept_byte    = head.kept_byte;
    assign o_byte_present = head.byte_present;
    assign o_final_result = head.final_result;

endmodule

// File: hw/rtl/cccs_filter.sv
// per-byte filter: color code state and the results of one transfer
module cccs_filter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_text_byte,
    input  logic           i_end_of_text,
    output cccs_pkg::t_push o_push
);
    import cccs_pkg::*;

    logic       r_in_code;
    logic [1:0] r_digit_count;
    logic       r_comma_seen;

    logic       n_in_code;
    logic [1:0] n_digit_count;
    logic       n_comma_seen;

    logic       is_open;
    logic       is_digit;
    logic       is_printable;
    logic       digit_ok;
    logic       comma_ok;
    logic       comma_back;
    logic       give_byte;
    logic       end_comma;
    logic [1:0] n_res;
    t_result    res_byte;
    t_result    res_comma;
    t_result    res_empty;

    always_comb begin
        is_open      = (i_text_byte == COLOR_OPEN_BYTE);
        is_digit     = (i_text_byte >= DIGIT_ZERO) && (i_text_byte <= DIGIT_NINE);
        is_printable = (i_text_byte >= FIRST_PRINTABLE) && (i_text_byte != DELETE_BYTE);
        digit_ok     = r_in_code && is_digit && (r_digit_count < MAX_DIGITS);
        comma_ok     = r_in_code && !digit_ok && (i_text_byte == COMMA_BYTE)
                       && !r_comma_seen && (r_digit_count != 2'd0);

        n_in_code     = r_in_code;
        n_digit_count = r_digit_count;
        n_comma_seen  = r_comma_seen;
        comma_back    = 1'b0;

        if (is_open) begin
            n_in_code     = 1'b1;
            n_digit_count = 2'd0;
            n_comma_seen  = 1'b0;
        end else if (digit_ok) begin
            n_digit_count = r_digit_count + 2'd1;
        end else if (comma_ok) begin
            n_comma_seen  = 1'b1;
            n_digit_count = 2'd0;
        end else if (r_in_code) begin
            // code ends on this byte; a bare comma is given back
            n_in_code  = 1'b0;
            comma_back = (r_digit_count == 2'd0) && r_comma_seen;
        end

        give_byte = !is_open && !digit_ok && !comma_ok && is_printable;
        end_comma = i_end_of_text && n_in_code && (n_digit_count == 2'd0) && n_comma_seen;

        res_byte  = '{kept_byte: i_text_byte, byte_present: 1'b1, final_result: 1'b0};
        res_comma = '{kept_byte: COMMA_BYTE, byte_present: 1'b1, final_result: 1'b0};
        res_empty = '{kept_byte: EMPTY_BYTE, byte_present: 1'b0, final_result: 1'b0};

        n_res = {1'b0, comma_back} + {1'b0, give_byte} + {1'b0, end_comma};

        if (comma_back) begin
            o_push.slot0 = res_comma;
        end else if (give_byte) begin
            o_push.slot0 = res_byte;
        end else if (end_comma) begin
            o_push.slot0 = res_comma;
        end else begin
            o_push.slot0 = res_empty;
        end
        o_push.slot1 = give_byte ? res_byte : res_comma;

        if (i_end_of_text && (n_res == 2'd0)) begin
            n_res = 2'd1;
        end
        if (i_end_of_text) begin
            if (n_res == 2'd2) begin
                o_push.slot1.final_result = 1'b1;
            end else begin
                o_push.slot0.final_result = 1'b1;
            end
        end

        o_push.count = i_accept ? n_res : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_code     <= 1'b0;
            r_digit_count <= 2'd0;
            r_comma_seen  <= 1'b0;
        end else if (i_accept) begin
            if (i_end_of_text) begin
                r_in_code     <= 1'b0;
                r_digit_count <= 2'd0;
                r_comma_seen  <= 1'b0;
            end else begin
                r_in_code     <= n_in_code;
                r_digit_count <= n_digit_count;
                r_comma_seen  <= n_comma_seen;
            end
        end
    end

endmodule

// File: hw/rtl/cccs_result_fifo.sv
// small result queue: takes up to two results per cycle, gives one
module cccs_result_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cccs_pkg::t_push   i_push,
    input  logic              i_pop,
    output logic              o_room_for_two,
    output logic              o_not_empty,
    output cccs_pkg::t_result o_head
);
    import cccs_pkg::*;

    t_result                r_entries [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count;

    logic [FIFO_PTR_W-1:0]  wr_ptr_next;
    logic                   pop_ok;

    assign wr_ptr_next    = r_wr_ptr + FIFO_PTR_W'(1);
    assign pop_ok         = i_pop && (r_count != '0);
    assign o_not_empty    = (r_count != '0);
    assign o_room_for_two = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign o_head         = r_entries[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_entries[r_wr_ptr] <= i_push.slot0;
        end
        if (i_push.count == 2'd2) begin
            r_entries[wr_ptr_next] <= i_push.slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(i_push.count);
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_count <= r_count + FIFO_CNT_W'(i_push.count) - FIFO_CNT_W'(pop_ok);
        end
    end

endmodule

// File: hw/rtl/cccs_checker.sv
// port-level checker for the color code control stripper, with its bind
module cccs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_kept_byte,
    input logic       o_byte_present,
    input logic       o_final_result
);
    import cccs_pkg::*;

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kept_byte)
            && $stable(o_byte_present) && $stable(o_final_result))
        else $error("stalled result changed");

    // an empty marker only ends a string, and carries a zero byte
    a_empty_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_present |-> o_final_result && (o_kept_byte == EMPTY_BYTE))
        else $error("empty result not a zero final marker");

    // control bytes never leave the block
    a_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_present |-> (o_kept_byte >= FIRST_PRINTABLE)
            && (o_kept_byte != DELETE_BYTE))
        else $error("control byte passed through");

endmodule

bind color_code_control_stripper cccs_checker u_cccs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_kept_byte    (o_kept_byte),
    .o_byte_present (o_byte_present),
    .o_final_result (o_final_result)
);
